// File: hdl/tlr_pkg.sv
// tlr_pkg: shared constants and types for the thick line rasterizer
// no dependencies; imported by the top level, tlr_front and tlr_back

package tlr_pkg;

  // item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // fixed field widths of the item channels
  localparam int START_X_W = 9;
  localparam int START_Y_W = 8;
  localparam int COLOUR_W  = 16;
  localparam int PIX_X_W   = 10;
  localparam int PIX_Y_W   = 9;

  // stamped box: row offsets BOX_LO..BOX_HI, columns BOX_HI down to BOX_LO
  localparam int BOX_LO   = -2;
  localparam int BOX_HI   = 3;
  localparam int BOX_SIZE = BOX_HI - BOX_LO + 1;
  localparam int BOX_IDX_W = $clog2(BOX_SIZE);
  localparam logic [BOX_IDX_W-1:0] BOX_LAST = BOX_IDX_W'(BOX_SIZE - 1);

  // back end status seen by the top level
  typedef struct packed {
    logic active;
    logic emit;
    logic last;
  } tlr_status_t;

endpackage

// File: hdl/thick_line_raster_draw.sv
// thick_line_raster_draw: top level of the thick line pixel generator
// depends on tlr_pkg, tlr_fifo, tlr_front and tlr_back
//
// Usage:
//   Input channel (push/full): func = FUNC_START loads two endpoints and a
//   colour and yields nothing; func = FUNC_STEP yields one pixel write while
//   a line is active, and nothing when no line is active. A start replaces a
//   line in progress. Each point of the line is stamped with a 6x6 box, so a
//   line of n points takes 36*n step items; the final one has last_pixel set.
//   Result channel (empty/pop): pixel_x, pixel_y (two's complement, not
//   clipped), pixel_colour and last_pixel of the oldest waiting pixel.
//   A step item is registered in the command queue and its pixel in the
//   output queue. Throughput: one item per cycle while the output queue has
//   room, set by the back end walker, which retires one command per cycle.
//   Two-entry queues sit between front end and back end and on the output.
//   When pop is held low the output queue fills, the walker stops, the
//   command queue fills and full rises; nothing is lost.
//   Reset empties both queues and leaves no line active.

module thick_line_raster_draw #(
  parameter int COORD_BITS = 9
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                func,
  input  logic [tlr_pkg::START_X_W-1:0]       start_x,
  input  logic [tlr_pkg::START_Y_W-1:0]       start_y,
  input  logic [tlr_pkg::START_X_W-1:0]       end_x,
  input  logic [tlr_pkg::START_Y_W-1:0]       end_y,
  input  logic [tlr_pkg::COLOUR_W-1:0]        line_colour,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [tlr_pkg::PIX_X_W-1:0]  pixel_x,
  output logic signed [tlr_pkg::PIX_Y_W-1:0]  pixel_y,
  output logic [tlr_pkg::COLOUR_W-1:0]        pixel_colour,
  output logic                                last_pixel
);

  import tlr_pkg::*;

  localparam int CB        = COORD_BITS;
  localparam int CMD_W     = 5 * CB + 3 + COLOUR_W;
  localparam int PIX_W     = PIX_X_W + PIX_Y_W + COLOUR_W + 1;
  localparam int CMD_DEPTH = 2;
  localparam int PIX_DEPTH = 2;

  // front end setup results
  logic          f_steep;
  logic [CB-1:0] f_major_pos, f_major_end, f_minor_pos;
  logic [CB-1:0] f_major_delta, f_minor_delta;
  logic          f_dir_down;

  // command queue
  logic [CMD_W-1:0] cmd_din, cmd_dout;
  logic             cmd_empty, cmd_pop;

  // back end fields
  logic          c_func, c_steep, c_dir_down;
  logic [CB-1:0] c_major_pos, c_major_end, c_minor_pos;
  logic [CB-1:0] c_major_delta, c_minor_delta;
  logic [COLOUR_W-1:0] c_colour;

  // pixel queue
  logic                out_push, out_full, out_last;
  logic [PIX_X_W-1:0]  out_x;
  logic [PIX_Y_W-1:0]  out_y;
  logic [COLOUR_W-1:0] out_colour;
  logic [PIX_W-1:0]    pix_dout;
  tlr_status_t         status;

  // line setup
  tlr_front #(.COORD_BITS(CB)) u_front (
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .steep          (f_steep),
    .major_pos      (f_major_pos),
    .major_end      (f_major_end),
    .minor_pos      (f_minor_pos),
    .major_delta    (f_major_delta),
    .minor_delta    (f_minor_delta),
    .minor_dir_down (f_dir_down)
  );

  assign cmd_din = {func, f_steep, f_major_pos, f_major_end, f_minor_pos,
                    f_major_delta, f_minor_delta, f_dir_down, line_colour};

  tlr_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_din),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign {c_func, c_steep, c_major_pos, c_major_end, c_minor_pos,
          c_major_delta, c_minor_delta, c_dir_down, c_colour} = cmd_dout;

  // line walker
  tlr_back #(.COORD_BITS(CB)) u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (!cmd_empty),
    .cmd_pop            (cmd_pop),
    .cmd_func           (c_func),
    .cmd_steep          (c_steep),
    .cmd_major_pos      (c_major_pos),
    .cmd_major_end      (c_major_end),
    .cmd_minor_pos      (c_minor_pos),
    .cmd_major_delta    (c_major_delta),
    .cmd_minor_delta    (c_minor_delta),
    .cmd_minor_dir_down (c_dir_down),
    .cmd_colour         (c_colour),
    .out_full           (out_full),
    .out_push           (out_push),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_colour         (out_colour),
    .out_last           (out_last),
    .status             (status)
  );

  // output queue
  tlr_fifo #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_pix_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   ({out_x, out_y, out_colour, out_last}),
    .full  (out_full),
    .pop   (pop),
    .dout  (pix_dout),
    .empty (empty)
  );

  assign {pixel_x, pixel_y, pixel_colour, last_pixel} = pix_dout;

`ifndef SYNTH
  // the walker never writes into a full pixel queue
  assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("pixel written while output queue full");

  // the final pixel of a line ends the line
  assert property (@(posedge clk) disable iff (rst)
    (status.emit && status.last) |=> !status.active)
    else $error("line still active after its last pixel");

  // reset leaves no result waiting and no line active
  assert property (@(posedge clk) rst |=> (empty && !status.active))
    else $error("state not cleared by reset");
`endif

endmodule

// File: hdl/tlr_fifo.sv
// tlr_fifo: small flop based first-in first-out queue
// no package dependencies; used for the command and pixel queues

module tlr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hdl/tlr_front.sv
// tlr_front: precomputes line setup for start items
// depends on tlr_pkg

module tlr_front #(
  parameter int COORD_BITS = 9
) (
  input  logic [tlr_pkg::START_X_W-1:0] start_x,
  input  logic [tlr_pkg::START_Y_W-1:0] start_y,
  input  logic [tlr_pkg::START_X_W-1:0] end_x,
  input  logic [tlr_pkg::START_Y_W-1:0] end_y,
  output logic                          steep,
  output logic [COORD_BITS-1:0]         major_pos,
  output logic [COORD_BITS-1:0]         major_end,
  output logic [COORD_BITS-1:0]         minor_pos,
  output logic [COORD_BITS-1:0]         major_delta,
  output logic [COORD_BITS-1:0]         minor_delta,
  output logic                          minor_dir_down
);

  import tlr_pkg::*;

  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] dx_abs, dy_abs;
  logic [COORD_BITS-1:0] a_maj, a_min, b_maj, b_min;
  logic                  swap;

  // coordinates wrap to the internal width
  assign ax = COORD_BITS'(start_x);
  assign ay = COORD_BITS'(start_y);
  assign bx = COORD_BITS'(end_x);
  assign by = COORD_BITS'(end_y);

  // absolute spans and axis choice
  assign dx_abs = (ax > bx) ? ax - bx : bx - ax;
  assign dy_abs = (ay > by) ? ay - by : by - ay;
  assign steep  = dy_abs > dx_abs;

  assign a_maj = steep ? ay : ax;
  assign a_min = steep ? ax : ay;
  assign b_maj = steep ? by : bx;
  assign b_min = steep ? bx : by;

  // order endpoints so the major axis counts up
  assign swap           = a_maj > b_maj;
  assign major_pos      = swap ? b_maj : a_maj;
  assign major_end      = swap ? a_maj : b_maj;
  assign minor_pos      = swap ? b_min : a_min;
  assign major_delta    = steep ? dy_abs : dx_abs;
  assign minor_delta    = steep ? dx_abs : dy_abs;
  assign minor_dir_down = swap ? !(b_min < a_min) : !(a_min < b_min);

endmodule

// File: hdl/tlr_back.sv
// tlr_back: walks the line and stamps the box, one pixel per step command while a line is active
// depends on tlr_pkg

module tlr_back #(
  parameter int COORD_BITS = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  logic                          cmd_func,
  input  logic                          cmd_steep,
  input  logic [COORD_BITS-1:0]         cmd_major_pos,
  input  logic [COORD_BITS-1:0]         cmd_major_end,
  input  logic [COORD_BITS-1:0]         cmd_minor_pos,
  input  logic [COORD_BITS-1:0]         cmd_major_delta,
  input  logic [COORD_BITS-1:0]         cmd_minor_delta,
  input  logic                          cmd_minor_dir_down,
  input  logic [tlr_pkg::COLOUR_W-1:0]  cmd_colour,
  // pixel side
  input  logic                          out_full,
  output logic                          out_push,
  output logic [tlr_pkg::PIX_X_W-1:0]   out_x,
  output logic [tlr_pkg::PIX_Y_W-1:0]   out_y,
  output logic [tlr_pkg::COLOUR_W-1:0]  out_colour,
  output logic                          out_last,
  output tlr_pkg::tlr_status_t          status
);

  import tlr_pkg::*;

  localparam int EW = COORD_BITS + 2;
  localparam int PW = COORD_BITS + 2;

  logic                  active;
  logic                  steep;
  logic [COORD_BITS-1:0] major_pos;
  logic [COORD_BITS-1:0] major_end;
  logic [COORD_BITS-1:0] minor_pos;
  logic [COORD_BITS-1:0] major_delta;
  logic [COORD_BITS-1:0] minor_delta;
  logic [EW-1:0]         error_acc;
  logic                  minor_dir_down;
  logic [BOX_IDX_W-1:0]  box_row;
  logic [BOX_IDX_W-1:0]  box_col;
  logic [COLOUR_W-1:0]   held_colour;

  logic                  is_start;
  logic                  do_step;
  logic                  last_box;
  logic                  row_end;
  logic                  col_end;
  logic [EW-1:0]         err_sum;
  logic                  err_pos;
  logic [COORD_BITS-1:0] x_base, y_base;
  logic [PW-1:0]         sum_x, sum_y;

  // command transfer when the pixel queue has room
  assign cmd_pop  = cmd_valid && !out_full;
  assign is_start = (cmd_func == FUNC_START);
  assign do_step  = cmd_pop && !is_start && active;

  // pixel position inside the box
  assign x_base = steep ? minor_pos : major_pos;
  assign y_base = steep ? major_pos : minor_pos;
  assign sum_x  = PW'(x_base) + PW'(BOX_HI) - PW'(box_col);
  assign sum_y  = PW'(y_base) + PW'(box_row) + PW'(BOX_LO);

  assign last_box = (major_pos == major_end);
  assign row_end  = (box_row == BOX_LAST);
  assign col_end  = (box_col == BOX_LAST);

  // bresenham error update
  assign err_sum = error_acc + EW'(minor_delta);
  assign err_pos = !err_sum[EW-1] && (err_sum != '0);

  assign out_push   = do_step;
  assign out_x      = sum_x[PIX_X_W-1:0];
  assign out_y      = sum_y[PIX_Y_W-1:0];
  assign out_colour = held_colour;
  assign out_last   = last_box && row_end && col_end;

  assign status.active = active;
  assign status.emit   = do_step;
  assign status.last   = out_last;

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      box_row <= '0;
      box_col <= '0;
    end else if (cmd_pop && is_start) begin
      active         <= 1'b1;
      box_row        <= '0;
      box_col        <= '0;
      steep          <= cmd_steep;
      major_pos      <= cmd_major_pos;
      major_end      <= cmd_major_end;
      minor_pos      <= cmd_minor_pos;
      major_delta    <= cmd_major_delta;
      minor_delta    <= cmd_minor_delta;
      minor_dir_down <= cmd_minor_dir_down;
      error_acc      <= EW'(0) - EW'(cmd_major_delta >> 1);
      held_colour    <= cmd_colour;
    end else if (do_step) begin
      if (!col_end) begin
        box_col <= box_col + BOX_IDX_W'(1);
      end else begin
        box_col <= '0;
        if (!row_end) begin
          box_row <= box_row + BOX_IDX_W'(1);
        end else begin
          box_row <= '0;
          if (last_box) begin
            active <= 1'b0;
          end else begin
            if (err_pos) begin
              minor_pos <= minor_dir_down ? minor_pos - COORD_BITS'(1)
                                          : minor_pos + COORD_BITS'(1);
              error_acc <= err_sum - EW'(major_delta);
            end else begin
              error_acc <= err_sum;
            end
            major_pos <= major_pos + COORD_BITS'(1);
          end
        end
      end
    end
  end

endmodule
